// ===== hdl/gmi_pkg.sv =====
`default_nettype none
package gmi_pkg;

    localparam int unsigned ROW_W      = 32;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned TAG_W      = 5;
    localparam int unsigned MAX_ORDER  = 32;
    localparam int unsigned ORDER_CAP  = 32;
    localparam logic [CNT_W-1:0] ORDER_RESET = 6'd32;
    localparam int unsigned OUT_DATA_W = 40;

    // One matrix row as it travels along the cell chain.
    typedef struct packed {
        logic [ROW_W-1:0] work;
        logic [ROW_W-1:0] inv;
        logic             used;
        logic [TAG_W-1:0] tag;
    } t_row;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ELIM,
        ST_READ,
        ST_SHOW
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/gmi_cell.sv =====
`default_nettype none
// One storage cell of the row chain. On a shift it takes its upper
// neighbor's row, or the tail row when it is the current last cell.
module gmi_cell (
    input  wire             i_clk,
    input  wire             i_shift,
    input  wire             i_is_tail,
    input  gmi_pkg::t_row   i_next,
    input  gmi_pkg::t_row   i_tail,
    output gmi_pkg::t_row   o_row
);
    gmi_pkg::t_row r_row;
    gmi_pkg::t_row n_row;

    always_comb begin
        n_row = r_row;
        if (i_shift) begin
            n_row = i_is_tail ? i_tail : i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
    end

    assign o_row = r_row;
endmodule
`default_nettype wire

// ===== hdl/gmi_ram.sv =====
`default_nettype none
module gmi_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

// ===== hdl/gf2_matrix_inverse.sv =====
// After the last row word of a matrix of order n is accepted, elimination
// rotates the row chain once per pivot column, then once more to write the
// results to the store, or stops early at a column without a pivot. Each
// result word is read, then shown; loading resumes after the last is taken.
// Reset (i_rst_n low, synchronous): order 32, no rows loaded, loading.
`default_nettype none
module gf2_matrix_inverse #(
    parameter int unsigned MAX_ORDER = gmi_pkg::MAX_ORDER
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Configuration: matrix_order.
    input  wire                               i_cfg_we,
    input  wire [gmi_pkg::CNT_W-1:0]          i_cfg_wdata,
    // Input word. tdata: row_bits[31:0].
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire [gmi_pkg::ROW_W-1:0]          s_axis_tdata,
    // Result word. tdata: inverse_row[31:0], row_number[36:32], zero pad.
    // tuser: invertible. tlast: last_row.
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [gmi_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);
    // The chain never needs more cells than the widest supported row.
    localparam int unsigned DEPTH = (MAX_ORDER < gmi_pkg::ORDER_CAP) ?
                                    MAX_ORDER : gmi_pkg::ORDER_CAP;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam logic [gmi_pkg::CNT_W-1:0] LIMIT = gmi_pkg::CNT_W'(DEPTH);

    gmi_pkg::t_state r_state, n_state;
    logic [gmi_pkg::CNT_W-1:0] r_order, r_loaded, r_col, r_pos, r_cnt;
    logic [gmi_pkg::CNT_W-1:0] n_loaded, n_col, n_pos, n_cnt;
    logic r_found, n_found, r_invert, n_invert;
    gmi_pkg::t_row r_piv, n_piv;      // pivot row of the previous column
    gmi_pkg::t_row r_cur, n_cur;      // pivot row captured in this pass

    // Effective order: zero acts as one, large values clip to the chain.
    logic [gmi_pkg::CNT_W-1:0] ord_n;
    always_comb begin
        ord_n = r_order;
        if (r_order == '0) ord_n = gmi_pkg::CNT_W'(1);
        if (r_order > LIMIT) ord_n = LIMIT;
    end

    logic [gmi_pkg::ROW_W-1:0] col_mask;
    always_comb begin
        for (int c = 0; c < gmi_pkg::ROW_W; c++) begin
            col_mask[c] = (gmi_pkg::CNT_W'(c) < ord_n);
        end
    end

    logic in_acc, out_acc;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Row chain: cell 0 is the head, the tail is cell n-1.
    gmi_pkg::t_row rows [DEPTH];
    gmi_pkg::t_row tail_row, head_a, load_row;
    logic          shift;

    assign shift = in_acc || (r_state == gmi_pkg::ST_ELIM);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        gmi_pkg::t_row nxt;
        if (g == DEPTH - 1) begin : g_last
            assign nxt = tail_row;
        end else begin : g_mid
            assign nxt = rows[g+1];
        end
        gmi_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (shift),
            .i_is_tail (gmi_pkg::CNT_W'(g) == ord_n - gmi_pkg::CNT_W'(1)),
            .i_next    (nxt),
            .i_tail    (tail_row),
            .o_row     (rows[g])
        );
    end

    // Head processing. A row first gets the previous column's pivot row
    // XORed in, then may become the pivot of the current column. Rows that
    // passed the head before this pivot was found are cleared in the next pass.
    logic [gmi_pkg::TAG_W-1:0] col_m1;
    logic prev_hit, take, col_live;
    assign col_m1   = gmi_pkg::TAG_W'(r_col - gmi_pkg::CNT_W'(1));
    assign col_live = (r_col < ord_n);

    always_comb begin
        prev_hit = (r_col != '0) && !(rows[0].used && rows[0].tag == col_m1)
                   && rows[0].work[col_m1];
        head_a = rows[0];
        if (prev_hit) begin
            head_a.work = rows[0].work ^ r_piv.work;
            head_a.inv  = rows[0].inv ^ r_piv.inv;
        end
        take = col_live && !r_found && !head_a.used
               && head_a.work[gmi_pkg::TAG_W'(r_col)];
    end

    always_comb begin
        load_row.work = s_axis_tdata & col_mask;
        load_row.inv  = gmi_pkg::ROW_W'(1) << r_loaded;
        load_row.used = 1'b0;
        load_row.tag  = '0;
        if (r_state == gmi_pkg::ST_ELIM) begin
            tail_row = head_a;
            if (take) begin
                tail_row.used = 1'b1;
                tail_row.tag  = gmi_pkg::TAG_W'(r_col);
            end
        end else begin
            tail_row = load_row;
        end
    end

    // Result store, addressed by the pivot column each row ended up owning.
    logic                      ram_we, ram_re;
    logic [gmi_pkg::ROW_W-1:0] ram_q;
    assign ram_we = (r_state == gmi_pkg::ST_ELIM) && !col_live;
    assign ram_re = (r_state == gmi_pkg::ST_READ);

    gmi_ram #(.WIDTH(gmi_pkg::ROW_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (rows[0].tag[AW-1:0]),
        .i_wdata (head_a.inv),
        .i_re    (ram_re),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (ram_q)
    );

    logic pass_end;
    assign pass_end = (r_pos == ord_n - gmi_pkg::CNT_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gmi_pkg::ST_LOAD: begin
                if (in_acc && (r_loaded + gmi_pkg::CNT_W'(1) >= ord_n)) begin
                    n_state = gmi_pkg::ST_ELIM;
                end
            end
            gmi_pkg::ST_ELIM: begin
                if (pass_end && (!col_live || !(r_found || take))) begin
                    n_state = gmi_pkg::ST_READ;
                end
            end
            gmi_pkg::ST_READ: n_state = gmi_pkg::ST_SHOW;
            gmi_pkg::ST_SHOW: begin
                if (out_acc) begin
                    n_state = m_axis_tlast ? gmi_pkg::ST_LOAD : gmi_pkg::ST_READ;
                end
            end
            default: n_state = gmi_pkg::ST_LOAD;
        endcase
    end

    // Datapath and counters.
    always_comb begin
        n_loaded = r_loaded;
        n_col    = r_col;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_found  = r_found;
        n_invert = r_invert;
        n_piv    = r_piv;
        n_cur    = r_cur;
        case (r_state)
            gmi_pkg::ST_LOAD: begin
                if (in_acc) begin
                    n_loaded = r_loaded + gmi_pkg::CNT_W'(1);
                    if (n_loaded >= ord_n) begin
                        n_loaded = '0;
                        n_col    = '0;
                        n_pos    = '0;
                        n_found  = 1'b0;
                        n_invert = 1'b1;
                    end
                end
            end
            gmi_pkg::ST_ELIM: begin
                if (take) begin
                    n_found = 1'b1;
                    n_cur   = tail_row;
                end
                n_pos = r_pos + gmi_pkg::CNT_W'(1);
                if (pass_end) begin
                    n_pos   = '0;
                    n_cnt   = '0;
                    n_col   = r_col + gmi_pkg::CNT_W'(1);
                    n_found = 1'b0;
                    n_piv   = take ? tail_row : r_cur;
                    if (col_live && !(r_found || take)) begin
                        n_invert = 1'b0;
                    end
                end
            end
            gmi_pkg::ST_SHOW: begin
                if (out_acc) n_cnt = r_cnt + gmi_pkg::CNT_W'(1);
            end
            default: ;
        endcase
        if (i_cfg_we) n_loaded = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gmi_pkg::ST_LOAD;
            r_order  <= gmi_pkg::ORDER_RESET;
            r_loaded <= '0;
            r_col    <= '0;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_found  <= 1'b0;
            r_invert <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_loaded <= n_loaded;
            r_col    <= n_col;
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
            r_found  <= n_found;
            r_invert <= n_invert;
            if (i_cfg_we) r_order <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_piv <= n_piv;
        r_cur <= n_cur;
    end

    // Outputs.
    always_comb begin
        s_axis_tready = (r_state == gmi_pkg::ST_LOAD);
        m_axis_tvalid = (r_state == gmi_pkg::ST_SHOW);
        m_axis_tdata  = {3'b000, r_cnt[gmi_pkg::TAG_W-1:0],
                         r_invert ? ram_q : {gmi_pkg::ROW_W{1'b0}}};
        m_axis_tuser  = r_invert;
        m_axis_tlast  = (r_cnt == ord_n - gmi_pkg::CNT_W'(1));
    end

    // Checks.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result word is shown");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("singular matrix gave a nonzero row");

    a_last_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && m_axis_tlast) |=> s_axis_tready)
        else $error("block did not return to loading after the last row");

endmodule
`default_nettype wire
